// ===== hdl/chacha_pkg.sv =====
package chacha_pkg;

    localparam int DOUBLE_ROUNDS_DEF = 10;

    localparam int CFG_ADDR_W = 6;
    localparam int CFG_DATA_W = 64;
    localparam int REG_IDX_W  = 3;
    localparam int REG_IDX_LSB = 3;

    localparam logic [REG_IDX_W-1:0] REG_KEY_A    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_KEY_B    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_KEY_C    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_KEY_D    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_NONCE_LO = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_NONCE_HI = 3'd5;

    localparam logic [31:0] SIGMA_0 = 32'h61707865;
    localparam logic [31:0] SIGMA_1 = 32'h3320646E;
    localparam logic [31:0] SIGMA_2 = 32'h79622D32;
    localparam logic [31:0] SIGMA_3 = 32'h6B206574;

    localparam logic [1:0] LAST_STEP = 2'd3;

    typedef logic [15:0][31:0] words_t;

    typedef struct packed {
        logic [63:0] key_a;
        logic [63:0] key_b;
        logic [63:0] key_c;
        logic [63:0] key_d;
        logic [63:0] nonce_lo;
        logic [31:0] nonce_hi;
    } chacha_cfg_t;

    typedef struct packed {
        logic       load_init;
        logic       round_en;
        logic       diag;
        logic [1:0] step;
        logic       final_add;
        logic       emit_direct;
    } dp_cmd_t;

    typedef struct packed {
        logic pos_zero;
    } dp_status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FINAL
    } ctrl_state_t;

endpackage

// ===== hdl/chacha20_byte_stream_cipher_unit.sv =====
// Timing: a byte at block position 0 gives its result after the block's rounds (ST_ROUND)
// and the final add (ST_FINAL); any other byte gives its result in the cycle after acceptance.
// Throughput: one byte per cycle inside a block while out_stall is low; input stalls while a
// 64-byte block is computed by four quarter-round lanes doing one add-xor-rotate step per cycle.
// Reset: rst_n is asynchronous, active low; it clears the registers, the block counter,
// the byte position and the output valid. The keystream words are not reset.
module chacha20_byte_stream_cipher_unit import chacha_pkg::*;
#(
    parameter int DOUBLE_ROUNDS = DOUBLE_ROUNDS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [7:0]            data_in,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [7:0]            data_out
);

    chacha_cfg_t          cfg_reg;
    logic                 wr_en;
    logic                 cfg_hit;
    logic [REG_IDX_W-1:0] reg_idx;
    dp_cmd_t              cmd;
    dp_status_t           status;

    assign pready  = 1'b1;
    assign reg_idx = paddr[REG_IDX_LSB +: REG_IDX_W];
    assign wr_en   = psel && penable && pwrite && pready;
    assign cfg_hit = wr_en && (reg_idx inside {[REG_KEY_A:REG_NONCE_HI]});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_KEY_A:    cfg_reg.key_a    <= pwdata;
                REG_KEY_B:    cfg_reg.key_b    <= pwdata;
                REG_KEY_C:    cfg_reg.key_c    <= pwdata;
                REG_KEY_D:    cfg_reg.key_d    <= pwdata;
                REG_NONCE_LO: cfg_reg.nonce_lo <= pwdata;
                REG_NONCE_HI: cfg_reg.nonce_hi <= pwdata[31:0];
                default:      cfg_reg          <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_KEY_A:    prdata = cfg_reg.key_a;
            REG_KEY_B:    prdata = cfg_reg.key_b;
            REG_KEY_C:    prdata = cfg_reg.key_c;
            REG_KEY_D:    prdata = cfg_reg.key_d;
            REG_NONCE_LO: prdata = cfg_reg.nonce_lo;
            REG_NONCE_HI: prdata = {32'd0, cfg_reg.nonce_hi};
            default:      prdata = '0;
        endcase
    end

    chacha_ctrl #(
        .DOUBLE_ROUNDS(DOUBLE_ROUNDS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .out_stall(out_stall),
        .status   (status),
        .in_stall (in_stall),
        .out_valid(out_valid),
        .cmd      (cmd)
    );

    chacha_datapath u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .clear   (cfg_hit),
        .cmd     (cmd),
        .data_in (data_in),
        .status  (status),
        .data_out(data_out)
    );

endmodule

// ===== hdl/chacha_ctrl.sv =====
module chacha_ctrl import chacha_pkg::*;
#(
    parameter int DOUBLE_ROUNDS = DOUBLE_ROUNDS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       out_stall,
    input  dp_status_t status,
    output logic       in_stall,
    output logic       out_valid,
    output dp_cmd_t    cmd
);

    localparam int RND_W = $clog2(2 * DOUBLE_ROUNDS);
    localparam logic [RND_W-1:0] LAST_ROUND = RND_W'(2 * DOUBLE_ROUNDS - 1);

    ctrl_state_t      state_reg, state_next;
    logic [1:0]       step_reg;
    logic [RND_W-1:0] round_reg;
    logic             out_valid_reg, out_valid_next;
    logic             accept;
    logic             last_beat;

    assign in_stall  = (state_reg != ST_IDLE) || (out_valid_reg && out_stall);
    assign out_valid = out_valid_reg;
    assign accept    = in_valid && !in_stall;
    assign last_beat = (step_reg == LAST_STEP) && (round_reg == LAST_ROUND);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && status.pos_zero)
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                if (last_beat)
                begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        cmd.diag = round_reg[0];
        cmd.step = step_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.load_init   = accept && status.pos_zero;
                cmd.emit_direct = accept && !status.pos_zero;
            end
            ST_ROUND:
            begin
                cmd.round_en = 1'b1;
            end
            ST_FINAL:
            begin
                cmd.final_add = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
        out_valid_next = (out_valid_reg && out_stall) || cmd.emit_direct || cmd.final_add;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            round_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (state_reg == ST_ROUND)
            begin
                step_reg <= step_reg + 2'd1;
                if (step_reg == LAST_STEP)
                begin
                    round_reg <= round_reg + RND_W'(1);
                end
            end
            else
            begin
                step_reg  <= '0;
                round_reg <= '0;
            end
        end
    end

endmodule

// ===== hdl/chacha_datapath.sv =====
module chacha_datapath import chacha_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  chacha_cfg_t cfg,
    input  logic        clear,
    input  dp_cmd_t     cmd,
    input  logic [7:0]  data_in,
    output dp_status_t  status,
    output logic [7:0]  data_out
);

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
    } qr_words_t;

    function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic qr_words_t qr_step(input qr_words_t q, input logic [1:0] s);
        qr_words_t r;
        r = q;
        case (s)
            2'd0:
            begin
                r.a = q.a + q.b;
                r.d = rotl(q.d ^ r.a, 16);
            end
            2'd1:
            begin
                r.c = q.c + q.d;
                r.b = rotl(q.b ^ r.c, 12);
            end
            2'd2:
            begin
                r.a = q.a + q.b;
                r.d = rotl(q.d ^ r.a, 8);
            end
            default:
            begin
                r.c = q.c + q.d;
                r.b = rotl(q.b ^ r.c, 7);
            end
        endcase
        return r;
    endfunction

    function automatic words_t mk_init(input chacha_cfg_t c, input logic [31:0] ctr);
        words_t v;
        v[0]  = SIGMA_0;
        v[1]  = SIGMA_1;
        v[2]  = SIGMA_2;
        v[3]  = SIGMA_3;
        v[4]  = c.key_a[31:0];
        v[5]  = c.key_a[63:32];
        v[6]  = c.key_b[31:0];
        v[7]  = c.key_b[63:32];
        v[8]  = c.key_c[31:0];
        v[9]  = c.key_c[63:32];
        v[10] = c.key_d[31:0];
        v[11] = c.key_d[63:32];
        v[12] = ctr;
        v[13] = c.nonce_lo[31:0];
        v[14] = c.nonce_lo[63:32];
        v[15] = c.nonce_hi;
        return v;
    endfunction

    words_t      w_reg;
    words_t      init_cur;
    words_t      init_inc;
    words_t      rnd_words;
    words_t      sum_words;
    qr_words_t   lane_in  [4];
    qr_words_t   lane_out [4];
    logic [31:0] ctr_reg;
    logic [5:0]  pos_reg;
    logic [7:0]  byte_reg;
    logic [7:0]  dout_reg;
    logic [31:0] ks_word;
    logic [7:0]  ks_byte;

    assign init_cur = mk_init(cfg, ctr_reg);
    assign init_inc = mk_init(cfg, ctr_reg + 32'd1);

    always_comb
    begin
        rnd_words = w_reg;
        for (int k = 0; k < 4; k++)
        begin
            lane_in[k].a = w_reg[k];
            lane_in[k].b = cmd.diag ? w_reg[4 + ((k + 1) & 3)]  : w_reg[4 + k];
            lane_in[k].c = cmd.diag ? w_reg[8 + ((k + 2) & 3)]  : w_reg[8 + k];
            lane_in[k].d = cmd.diag ? w_reg[12 + ((k + 3) & 3)] : w_reg[12 + k];
            lane_out[k]  = qr_step(lane_in[k], cmd.step);
            rnd_words[k] = lane_out[k].a;
            if (cmd.diag)
            begin
                rnd_words[4 + ((k + 1) & 3)]  = lane_out[k].b;
                rnd_words[8 + ((k + 2) & 3)]  = lane_out[k].c;
                rnd_words[12 + ((k + 3) & 3)] = lane_out[k].d;
            end
            else
            begin
                rnd_words[4 + k]  = lane_out[k].b;
                rnd_words[8 + k]  = lane_out[k].c;
                rnd_words[12 + k] = lane_out[k].d;
            end
        end
        for (int i = 0; i < 16; i++)
        begin
            sum_words[i] = w_reg[i] + init_cur[i];
        end
    end

    assign ks_word = w_reg[pos_reg[5:2]];
    assign ks_byte = ks_word[{pos_reg[1:0], 3'b000} +: 8];

    assign status.pos_zero = (pos_reg == 6'd0);
    assign data_out        = dout_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctr_reg <= '0;
            pos_reg <= '0;
        end
        else if (clear)
        begin
            ctr_reg <= '0;
            pos_reg <= '0;
        end
        else
        begin
            if (cmd.load_init)
            begin
                ctr_reg <= ctr_reg + 32'd1;
            end
            if (cmd.emit_direct || cmd.final_add)
            begin
                pos_reg <= pos_reg + 6'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_init)
        begin
            w_reg    <= init_inc;
            byte_reg <= data_in;
        end
        else if (cmd.round_en)
        begin
            w_reg <= rnd_words;
        end
        else if (cmd.final_add)
        begin
            w_reg <= sum_words;
        end

        if (cmd.emit_direct)
        begin
            dout_reg <= data_in ^ ks_byte;
        end
        else if (cmd.final_add)
        begin
            dout_reg <= byte_reg ^ sum_words[0][7:0];
        end
    end

endmodule

// ===== hdl/chacha_checker.sv =====
module chacha_checker import chacha_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  psel,
    input logic                  penable,
    input logic                  pwrite,
    input logic [CFG_ADDR_W-1:0] paddr,
    input logic [CFG_DATA_W-1:0] pwdata,
    input logic [CFG_DATA_W-1:0] prdata,
    input logic                  pready,
    input logic                  in_valid,
    input logic                  in_stall,
    input logic                  out_valid,
    input logic                  out_stall,
    input logic [7:0]            data_out
);

    logic key_a_wr;

    assign key_a_wr = psel && penable && pwrite && pready
                      && (paddr[REG_IDX_LSB +: REG_IDX_W] == REG_KEY_A);

    // hold a stalled beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(data_out))
        else $error("stalled output beat changed");

    // a full, stalled output slot blocks input
    a_in_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |-> in_stall)
        else $error("input taken while output slot is held");

    // a new result comes from a beat just taken or from block work
    a_out_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid) || $past(in_stall))
        else $error("result without a source beat");

    // read back the written key A register
    a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
        $past(key_a_wr) && (paddr[REG_IDX_LSB +: REG_IDX_W] == REG_KEY_A)
        |-> prdata == $past(pwdata))
        else $error("register read does not return written value");

endmodule

bind chacha20_byte_stream_cipher_unit chacha_checker u_chk (.*);
